// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TZPD_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define TZPD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: sv/tzpd_pkg.sv
package tzpd_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned ConfW = 8;
	localparam int unsigned DistW = 16;
	localparam int unsigned DirW  = 2;
	localparam int unsigned InDataW  = 64;
	localparam int unsigned OutDataW = 64;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 32;

	localparam logic [ConfW-1:0] ConfThresholdRst   = 8'd50;
	localparam logic [TimeW-1:0] ApproachTimeoutRst = 32'd2000;
	localparam logic [TimeW-1:0] InZoneTimeoutRst   = 32'd2500;
	localparam logic [TimeW-1:0] CooldownTimeRst    = 32'd8000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CONF_THRESHOLD   = 2'd0,
		REG_APPROACH_TIMEOUT = 2'd1,
		REG_IN_ZONE_TIMEOUT  = 2'd2,
		REG_COOLDOWN_TIME    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_APPROACH = 2'd1,
		PH_INZONE   = 2'd2,
		PH_COOLDOWN = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OUT_NONE   = 2'd0,
		OUT_DONE   = 2'd1,
		OUT_CANCEL = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [ConfW-1:0] conf_threshold;
		logic [TimeW-1:0] approach_timeout;
		logic [TimeW-1:0] in_zone_timeout;
		logic [TimeW-1:0] cooldown_time;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] now_time;
		logic             tgt_present;
		logic [ConfW-1:0] sight_confidence;
		logic             first_zone;
		logic             second_zone;
		logic [DistW-1:0] distance;
		logic [DirW-1:0]  heading_hint;
	} obs_t;

	typedef struct packed {
		phase_t           phase;
		logic [TimeW-1:0] phase_start;
		logic [TimeW-1:0] cooldown_end;
	} state_t;

	typedef struct packed {
		outcome_t         outcome;
		logic [TimeW-1:0] event_time;
		logic [DistW-1:0] event_distance;
		logic [ConfW-1:0] event_confidence;
		logic [DirW-1:0]  event_direction;
	} result_t;

endpackage

// File: sv/tzpd_core.sv
module tzpd_core
	import tzpd_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  cur,
	input  obs_t    obs,
	output state_t  nxt,
	output result_t res
);

	logic [TimeW-1:0] since_cd_end;
	logic [TimeW-1:0] elapsed;
	logic [TimeW-1:0] cd_end_new;
	phase_t           eff_phase;

	assign since_cd_end = obs.now_time - cur.cooldown_end;
	assign elapsed      = obs.now_time - cur.phase_start;
	assign cd_end_new   = obs.now_time + cfg.cooldown_time;

	// A cooldown that has run out falls back to idle and the same request is handled there.
	always_comb begin
		eff_phase = cur.phase;
		if (cur.phase == PH_COOLDOWN && !since_cd_end[TimeW-1]) begin
			eff_phase = PH_IDLE;
		end
	end

	always_comb begin
		nxt       = cur;
		nxt.phase = eff_phase;
		res       = '0;
		res.outcome = OUT_NONE;
		case (eff_phase)
			PH_IDLE: begin
				if (obs.tgt_present && obs.sight_confidence >= cfg.conf_threshold) begin
					nxt.phase       = PH_APPROACH;
					nxt.phase_start = obs.now_time;
				end
			end
			PH_APPROACH: begin
				if (obs.second_zone && !obs.first_zone) begin
					nxt.phase        = PH_COOLDOWN;
					nxt.cooldown_end = cd_end_new;
					res.outcome      = OUT_CANCEL;
				end else if (obs.first_zone) begin
					nxt.phase       = PH_INZONE;
					nxt.phase_start = obs.now_time;
				end else if (!obs.tgt_present || elapsed > cfg.approach_timeout) begin
					nxt.phase        = PH_COOLDOWN;
					nxt.cooldown_end = cd_end_new;
					res.outcome      = OUT_CANCEL;
				end
			end
			PH_INZONE: begin
				if (obs.second_zone) begin
					nxt.phase            = PH_COOLDOWN;
					nxt.cooldown_end     = cd_end_new;
					res.outcome          = OUT_DONE;
					res.event_time       = obs.now_time;
					res.event_distance   = obs.distance;
					res.event_confidence = obs.sight_confidence;
					res.event_direction  = obs.heading_hint;
				end else if (!obs.tgt_present || elapsed > cfg.in_zone_timeout) begin
					nxt.phase        = PH_COOLDOWN;
					nxt.cooldown_end = cd_end_new;
					res.outcome      = OUT_CANCEL;
				end
			end
			default: begin
				nxt.phase = PH_COOLDOWN;
			end
		endcase
	end

endmodule

// File: sv/two_zone_passage_detector_unit.sv
// An accepted request is stored in the input register, its result in the output register.
// Throughput: one request per cycle unless the master side stalls; every request yields exactly one result.
// The input register feeds the phase logic, whose result and new state are
// stored together when the output register is free to take them.
// Reset (arst_n low, asynchronous) sets the idle phase, clears both times
// and loads the default register values.
module two_zone_passage_detector_unit
	import tzpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// now_time, tgt_present, sight_confidence, first_zone, second_zone, distance,
	// heading_hint, zero fill
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// event_time, event_distance, event_confidence, event_direction, zero fill
	output logic [OutDataW-1:0] m_tdata,
	// outcome
	output logic [1:0]          m_tuser
);

	cfg_t    cfg_q;
	state_t  state_q;
	obs_t    obs_s1;
	logic    vld_s1;
	result_t res_s2;
	logic    vld_s2;
	state_t  state_nxt;
	result_t res_nxt;
	logic    advance;

	assign advance  = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_threshold   <= ConfThresholdRst;
			cfg_q.approach_timeout <= ApproachTimeoutRst;
			cfg_q.in_zone_timeout  <= InZoneTimeoutRst;
			cfg_q.cooldown_time    <= CooldownTimeRst;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_CONF_THRESHOLD:   cfg_q.conf_threshold   <= cfg_wdata[ConfW-1:0];
				REG_APPROACH_TIMEOUT: cfg_q.approach_timeout <= cfg_wdata[TimeW-1:0];
				REG_IN_ZONE_TIMEOUT:  cfg_q.in_zone_timeout  <= cfg_wdata[TimeW-1:0];
				REG_COOLDOWN_TIME:    cfg_q.cooldown_time    <= cfg_wdata[TimeW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			obs_s1.now_time         <= s_tdata[31:0];
			obs_s1.tgt_present      <= s_tdata[32];
			obs_s1.sight_confidence <= s_tdata[40:33];
			obs_s1.first_zone       <= s_tdata[41];
			obs_s1.second_zone      <= s_tdata[42];
			obs_s1.distance         <= s_tdata[58:43];
			obs_s1.heading_hint     <= s_tdata[60:59];
		end
	end

	tzpd_core u_core (
		.cfg (cfg_q),
		.cur (state_q),
		.obs (obs_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.phase_start  <= '0;
			state_q.cooldown_end <= '0;
			vld_s2               <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.outcome;
	assign m_tdata  = {6'd0, res_s2.event_direction, res_s2.event_confidence,
		res_s2.event_distance, res_s2.event_time};

endmodule

// File: sv/tzpd_checker.sv
`include "assert_macros.svh"

module tzpd_checker
	import tzpd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	`TZPD_ASSERT(a_outcome_known, m_tvalid, m_tuser == OUT_NONE || m_tuser == OUT_DONE || m_tuser == OUT_CANCEL, "Outcome code out of range")
	`TZPD_ASSERT(a_data_zero, m_tvalid && m_tuser != OUT_DONE, m_tdata == '0, "Event data set without a completed passage")
	`TZPD_ASSERT(a_ready_when_empty, !m_tvalid, s_tready, "Input stalled while the output is empty")
	`TZPD_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result changed")

endmodule

bind two_zone_passage_detector_unit tzpd_checker u_tzpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
